// File: design/cmac_pkg.sv
package cmac_pkg;

  localparam int RK_DEPTH = 11;
  localparam int RK_AW    = $clog2(RK_DEPTH);
  localparam int BLK_W    = 128;
  localparam int HALF_W   = 64;
  localparam int CNT_W    = 5;
  localparam int LAST_RND = 10;

  localparam logic [7:0] CMAC_RB  = 8'h87;
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEXP,
    S_SUBK,
    S_PROC,
    S_CHAIN,
    S_TAG,
    S_OUT_HI,
    S_OUT_LO
  } cmac_state_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [RK_AW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] v, input int k);
    return v[BLK_W-1-8*k -: 8];
  endfunction

  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                 input logic last);
    logic [7:0] t [0:15];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLK_W-1:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = SBOX[get_byte(s, ((c + i) % 4) * 4 + i)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[c*4];
      a1 = t[c*4+1];
      a2 = t[c*4+2];
      a3 = t[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[BLK_W-1-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[BLK_W-1-32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BLK_W-1:0] dbl(input logic [BLK_W-1:0] v);
    return {v[BLK_W-2:0], 1'b0} ^ {{(BLK_W-8){1'b0}}, (v[BLK_W-1] ? CMAC_RB : 8'h00)};
  endfunction

endpackage

// File: design/aes_cmac_tag_generator_core.sv
// AES-128 CMAC tag generator over a byte stream. Keys are written through the APB port
// (key_high at 0x0, key_low at 0x8); a key write makes the next request first expand the
// eleven round keys into the round-key RAM and encrypt zero for the subkeys. When a
// request that carries a byte opens a new block after a full one, the held block is
// chained first through the one-round-per-cycle AES core. End of message adds the final
// encryption, then the tag leaves as two 64-bit halves, upper first. The AES core reads
// one round key from the RAM each cycle.
module aes_cmac_tag_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_tag_half,
  output logic        out_tag_last
);
  import cmac_pkg::*;

  cmac_state_t state_r, state_nxt;
  logic [BLK_W-1:0] key_r, key_nxt;
  logic             ready_r, ready_nxt;
  logic [7:0]       pb_r, pb_nxt;
  logic             pp_r, pp_nxt;
  logic             pe_r, pe_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BLK_W-1:0] chain_r, chain_nxt;
  logic [BLK_W-1:0] k1_r, k1_nxt;
  logic [BLK_W-1:0] k2_r, k2_nxt;
  logic [BLK_W-1:0] st_r, st_nxt;
  logic [RK_AW-1:0] rnd_r, rnd_nxt;
  logic [BLK_W-1:0] rk_r, rk_nxt;
  logic [RK_AW-1:0] kx_r, kx_nxt;
  logic [BLK_W-1:0] tag_r, tag_nxt;

  logic             cfg_wr, in_acc, enc_on, enc_done, blk_full;
  logic [RK_AW-1:0] raddr;
  logic [BLK_W-1:0] rd, enc_res, pad_blk, last_in;
  logic [BLK_W-1:0] l_val;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? key_r[HALF_W-1:0] : key_r[BLK_W-1:HALF_W];

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = (state_r == S_OUT_HI) || (state_r == S_OUT_LO);
  assign out_tag_last = (state_r == S_OUT_LO);
  assign out_tag_half = out_tag_last ? tag_r[HALF_W-1:0] : tag_r[BLK_W-1:HALF_W];

  assign enc_on   = (state_r == S_SUBK) || (state_r == S_CHAIN) || (state_r == S_TAG);
  assign enc_done = (rnd_r == RK_AW'(LAST_RND));
  assign blk_full = (cnt_r == CNT_W'(16));
  assign raddr    = (enc_on && !enc_done) ? rnd_r + 1'b1 : '0;
  assign enc_res  = (rnd_r == '0) ? (st_r ^ rd) : (aes_round(st_r, enc_done) ^ rd);
  assign l_val    = dbl(enc_res);

  cmac_ram #(.WIDTH(BLK_W), .DEPTH(RK_DEPTH)) u_rk_ram (
    .clk  (clk),
    .we   (state_r == S_KEXP),
    .waddr(kx_r),
    .wdata(rk_r),
    .raddr(raddr),
    .rdata(rd)
  );

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        pad_blk[BLK_W-1-8*i -: 8] = blk_r[BLK_W-1-8*i -: 8];
      end else if (CNT_W'(i) == cnt_r) begin
        pad_blk[BLK_W-1-8*i -: 8] = PAD_MARK;
      end else begin
        pad_blk[BLK_W-1-8*i -: 8] = 8'h00;
      end
    end
    last_in = blk_full ? (chain_r ^ blk_r ^ k1_r) : (chain_r ^ pad_blk ^ k2_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = ready_r ? S_PROC : S_KEXP;
        end
      end
      S_KEXP: begin
        if (kx_r == RK_AW'(LAST_RND)) begin
          state_nxt = S_SUBK;
        end
      end
      S_SUBK, S_CHAIN: begin
        if (enc_done) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (pp_r) begin
          state_nxt = blk_full ? S_CHAIN : S_PROC;
        end else if (pe_r) begin
          state_nxt = S_TAG;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TAG: begin
        if (enc_done) begin
          state_nxt = S_OUT_HI;
        end
      end
      S_OUT_HI: begin
        if (!out_stall) begin
          state_nxt = S_OUT_LO;
        end
      end
      S_OUT_LO: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    key_nxt   = key_r;
    ready_nxt = ready_r;
    pb_nxt    = pb_r;
    pp_nxt    = pp_r;
    pe_nxt    = pe_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    chain_nxt = chain_r;
    k1_nxt    = k1_r;
    k2_nxt    = k2_r;
    st_nxt    = st_r;
    rnd_nxt   = rnd_r;
    rk_nxt    = rk_r;
    kx_nxt    = kx_r;
    tag_nxt   = tag_r;
    if (cfg_wr) begin
      if (paddr[3]) begin
        key_nxt[HALF_W-1:0] = pwdata;
      end else begin
        key_nxt[BLK_W-1:HALF_W] = pwdata;
      end
      ready_nxt = 1'b0;
    end
    if (enc_on) begin
      st_nxt  = enc_res;
      rnd_nxt = rnd_r + 1'b1;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pb_nxt = in_data_byte;
          pp_nxt = in_byte_present;
          pe_nxt = in_end_of_message;
          rk_nxt = key_r;
          kx_nxt = '0;
        end
      end
      S_KEXP: begin
        rk_nxt = key_next(rk_r, rcon(kx_r + 1'b1));
        kx_nxt = kx_r + 1'b1;
        st_nxt = '0;
        rnd_nxt = '0;
      end
      S_SUBK: begin
        if (enc_done) begin
          k1_nxt    = l_val;
          k2_nxt    = dbl(l_val);
          ready_nxt = 1'b1;
        end
      end
      S_CHAIN: begin
        if (enc_done) begin
          chain_nxt = enc_res;
          cnt_nxt   = '0;
        end
      end
      S_PROC: begin
        rnd_nxt = '0;
        if (pp_r) begin
          if (blk_full) begin
            st_nxt = chain_r ^ blk_r;
          end else begin
            for (int i = 0; i < 16; i++) begin
              if (cnt_r[3:0] == 4'(i)) begin
                blk_nxt[BLK_W-1-8*i -: 8] = pb_r;
              end
            end
            cnt_nxt = cnt_r + 1'b1;
            pp_nxt  = 1'b0;
          end
        end else begin
          st_nxt = last_in;
        end
      end
      S_TAG: begin
        if (enc_done) begin
          tag_nxt   = enc_res;
          chain_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_r   <= '0;
      ready_r <= 1'b0;
      cnt_r   <= '0;
      chain_r <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      ready_r <= ready_nxt;
      cnt_r   <= cnt_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pb_r  <= pb_nxt;
    pp_r  <= pp_nxt;
    pe_r  <= pe_nxt;
    blk_r <= blk_nxt;
    k1_r  <= k1_nxt;
    k2_r  <= k2_nxt;
    st_r  <= st_nxt;
    rnd_r <= rnd_nxt;
    rk_r  <= rk_nxt;
    kx_r  <= kx_nxt;
    tag_r <= tag_nxt;
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while tag pending");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(16)) else $error("block byte count overflow");
  a_tag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAG && enc_done) |=> (state_r == S_OUT_HI && cnt_r == '0))
    else $error("tag not presented after final encryption");
  a_proc_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROC) |-> ready_r) else $error("message processed without subkeys");
endmodule

// File: design/cmac_ram.sv
module cmac_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: verif/tb_aes_cmac_tag_generator_core.sv
module tb_aes_cmac_tag_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cmac_pkg::*;

  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [7:0] ROUND_CONST [0:10] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                                8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } byte_req_t;

  typedef struct {
    logic [63:0] tag_half;
    logic        tag_last;
  } tag_half_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_present;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_tag_half;
  logic        out_tag_last;

  aes_cmac_tag_generator_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tag_half      (out_tag_half),
    .out_tag_last      (out_tag_last)
  );

  byte_req_t   pending_reqs [$];
  tag_half_t   expected_tags [$];
  int          error_count;
  int          accepted_reqs;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_cycles;
  bit          hold_done;
  bit          req_taken;

  logic [127:0] cmac_key;
  logic [127:0] round_keys [0:10];
  logic [127:0] chain_state;
  logic [127:0] subkey1;
  logic [127:0] subkey2;
  logic [7:0]   msg_block [0:15];
  int           block_fill;
  bit           keys_ready;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] plain);
    logic [7:0] s [0:15];
    logic [7:0] t [0:15];
    logic [7:0] a0, a1, a2, a3, mix;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = plain[127-8*i -: 8] ^ round_keys[0][127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = SBOX[s[((c + i) % 4) * 4 + i]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        mix = a0 ^ a1 ^ a2 ^ a3;
        if (r < 10) begin
          s[c*4]   = a0 ^ mix ^ gf_double(a0 ^ a1);
          s[c*4+1] = a1 ^ mix ^ gf_double(a1 ^ a2);
          s[c*4+2] = a2 ^ mix ^ gf_double(a2 ^ a3);
          s[c*4+3] = a3 ^ mix ^ gf_double(a3 ^ a0);
        end else begin
          s[c*4]   = a0;
          s[c*4+1] = a1;
          s[c*4+2] = a2;
          s[c*4+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[r][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [127:0] gf_shift(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
  endfunction

  task automatic derive_subkeys();
    logic [31:0] w [0:43];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = cmac_key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0)
        t = {SBOX[t[23:16]] ^ ROUND_CONST[i/4], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    subkey1 = gf_shift(aes_encrypt(128'd0));
    subkey2 = gf_shift(subkey1);
    keys_ready = 1'b1;
  endtask

  task automatic predict_tag(input byte_req_t req);
    logic [127:0] blk;
    logic [127:0] tag;
    if (!keys_ready) derive_subkeys();
    if (req.byte_present) begin
      if (block_fill >= 16) begin
        for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = msg_block[i];
        chain_state = aes_encrypt(chain_state ^ blk);
        block_fill = 0;
      end
      msg_block[block_fill] = req.data_byte;
      block_fill++;
    end
    if (req.end_of_message) begin
      for (int i = 0; i < 16; i++)
        blk[127-8*i -: 8] = (i < block_fill) ? msg_block[i] :
                            (i == block_fill) ? PAD_MARK : 8'h00;
      tag = aes_encrypt(chain_state ^ blk ^ ((block_fill >= 16) ? subkey1 : subkey2));
      expected_tags.push_back('{tag[127:64], 1'b0});
      expected_tags.push_back('{tag[63:0], 1'b1});
      chain_state = '0;
      block_fill = 0;
    end
  endtask

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_KEY_HIGH) cmac_key[127:64] = data;
    else cmac_key[63:0] = data;
    keys_ready = 1'b0;
  endtask

  task automatic load_key(input logic [127:0] key);
    while (pending_reqs.size() != 0 || expected_tags.size() != 0 || in_valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(ADDR_KEY_HIGH, key[127:64]);
    apb_write(ADDR_KEY_LOW, key[63:0]);
  endtask

  task automatic queue_msg(input int len, input int idle_pct, input bit close_with_byte);
    byte_req_t req;
    for (int i = 0; i < len; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        req = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b0};
        pending_reqs.push_back(req);
      end
      req = '{data_byte: 8'($urandom), byte_present: 1'b1,
              end_of_message: (close_with_byte && i == len - 1)};
      pending_reqs.push_back(req);
    end
    if (!close_with_byte || len == 0) begin
      req = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b1};
      pending_reqs.push_back(req);
    end
  endtask

  task automatic queue_fixed(input logic [7:0] value, input int len);
    for (int i = 0; i < len; i++)
      pending_reqs.push_back('{data_byte: value, byte_present: 1'b1,
                               end_of_message: (i == len - 1)});
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    req_taken <= 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      predict_tag('{in_data_byte, in_byte_present, in_end_of_message});
      accepted_reqs <= accepted_reqs + 1;
      req_taken <= 1'b1;
    end
  end

  always @(negedge clk) begin
    byte_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid          <= 1'b1;
        in_data_byte      <= nxt.data_byte;
        in_byte_present   <= nxt.byte_present;
        in_end_of_message <= nxt.end_of_message;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!hold_done && accepted_reqs >= 300) begin
      hold_done   <= 1'b1;
      hold_cycles <= 600;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    tag_half_t exp_half;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected tag half %h last %b", $realtime, out_tag_half, out_tag_last);
        error_count++;
      end else begin
        exp_half = expected_tags.pop_front();
        if (out_tag_half !== exp_half.tag_half) begin
          $display("%0t: tag_half expected %h actual %h", $realtime, exp_half.tag_half,
                   out_tag_half);
          error_count++;
        end
        if (out_tag_last !== exp_half.tag_last) begin
          $display("%0t: tag_last expected %b actual %b", $realtime, exp_half.tag_last,
                   out_tag_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (accepted_reqs < 250) begin
      tx_idle_pct <= 20;
      rx_idle_pct <= 74;
    end else if (accepted_reqs < 500) begin
      tx_idle_pct <= 74;
      rx_idle_pct <= 20;
    end else begin
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_KEY_HIGH;
    pwdata = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_present = 1'b0;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    accepted_reqs = 0;
    cycle_count = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 74;
    hold_cycles = 0;
    hold_done = 1'b0;
    req_taken = 1'b0;
    cmac_key = '0;
    chain_state = '0;
    block_fill = 0;
    keys_ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_reqs.push_back('{8'h00, 1'b0, 1'b0});
    pending_reqs.push_back('{8'h00, 1'b0, 1'b1});
    queue_fixed(8'h00, 16);
    load_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
    pending_reqs.push_back('{8'hff, 1'b0, 1'b1});
    queue_fixed(8'hff, 1);
    queue_msg(17, 0, 1'b0);
    queue_msg(16, 0, 1'b0);
    queue_msg(3, 0, 1'b0);
    queue_msg(20, 20, 1'b0);
    load_key({128{1'b1}});
    queue_msg(5, 0, 1'b1);
    queue_msg(9, 0, 1'b0);

    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 6; m++)
        queue_msg($urandom_range(40), $urandom_range(1) ? 0 : 15, $urandom_range(1));
      queue_msg($urandom_range(5, 12), 0, 1'b0);
      pending_reqs.push_back('{8'($urandom), 1'b1, 1'b0});
      load_key({$urandom, $urandom, $urandom, $urandom});
    end
    queue_msg(12, 0, 1'b1);
    load_key(128'd0);
    queue_msg(33, 10, 1'b1);

    while (pending_reqs.size() != 0 || in_valid || expected_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
